### hdl/ffsca_pkg.sv
// ffsca_pkg: shared constants, types and the microcode table of the first-fit allocator
// used by ffsca_seq, ffsca_dp, the core top level and its checker
package ffsca_pkg;

    localparam int MAX_BLOCKS    = 64;
    localparam int HEADER_BYTES  = 8;
    localparam int LARGEST_CLASS = 16384;
    localparam int IDX_W         = $clog2(MAX_BLOCKS);
    localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);
    localparam int USED_W        = 15;
    localparam int CLASS_W       = 3;
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 16;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_OP_RZ,
        S_ALLOC,
        S_TOO_BIG,
        S_PLACE_INIT,
        S_PLACE_SCAN,
        S_PLACE_HIT,
        S_APPEND_CHK,
        S_FULL,
        S_APPEND,
        S_MOVE,
        S_FREE,
        S_RZ,
        S_FIND_INIT,
        S_FIND_SCAN,
        S_NOT_FOUND,
        S_FOUND,
        S_FREE_K,
        S_RZ_CHK,
        S_RZ_IN,
        S_EMIT
    } t_step;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_SCAN_INIT,
        DP_SCAN_FIND,
        DP_SCAN_PLACE,
        DP_LATCH_K,
        DP_PLACE_HIT,
        DP_APPEND,
        DP_MOVE,
        DP_FREE_K,
        DP_RESIZE_IN,
        DP_ST_TOO_BIG,
        DP_ST_FULL,
        DP_ST_NOT_FOUND
    } t_dp_act;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_START,
        COND_OP_ALLOC,
        COND_OP_FREE,
        COND_OP_RESIZE,
        COND_SIZE_ZERO,
        COND_SIZE_BIG,
        COND_ADDR_ZERO,
        COND_SCAN_END,
        COND_HIT_FIND,
        COND_HIT_PLACE,
        COND_FULL,
        COND_FITS_IN,
        COND_MOVING
    } t_cond;

    typedef struct packed {
        t_dp_act act;
        t_cond   cond_a;
        t_step   tgt_a;
        t_cond   cond_b;
        t_step   tgt_b;
        t_step   nxt;
    } t_cw;

    typedef struct packed {
        logic op_alloc;
        logic op_free;
        logic op_resize;
        logic size_zero;
        logic size_big;
        logic addr_zero;
        logic scan_end;
        logic hit_find;
        logic hit_place;
        logic full;
        logic fits_in;
        logic moving;
    } t_flags;

    function automatic logic [USED_W-1:0] class_bytes(input logic [CLASS_W-1:0] code);
        logic [USED_W-1:0] bytes;
        case (code)
            3'd0:    bytes = 15'd16;
            3'd1:    bytes = 15'd64;
            3'd2:    bytes = 15'd256;
            3'd3:    bytes = 15'd1024;
            3'd4:    bytes = 15'd4096;
            default: bytes = 15'd16384;
        endcase
        return bytes;
    endfunction

    function automatic logic [CLASS_W-1:0] fit_class(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] code;
        if (size <= 16'd16)        code = 3'd0;
        else if (size <= 16'd64)   code = 3'd1;
        else if (size <= 16'd256)  code = 3'd2;
        else if (size <= 16'd1024) code = 3'd3;
        else if (size <= 16'd4096) code = 3'd4;
        else                       code = 3'd5;
        return code;
    endfunction

    function automatic t_cw mk(input t_dp_act act, input t_cond ca, input t_step ta,
                               input t_cond cb, input t_step tb, input t_step nx);
        t_cw w;
        w.act    = act;
        w.cond_a = ca;
        w.tgt_a  = ta;
        w.cond_b = cb;
        w.tgt_b  = tb;
        w.nxt    = nx;
        return w;
    endfunction

    // control store: action, first jump, second jump, fall-through step
    function automatic t_cw ucode(input t_step s);
        t_cw w;
        case (s)
            S_IDLE:       w = mk(DP_NOP, COND_START, S_DISPATCH, COND_NONE, S_IDLE, S_IDLE);
            S_DISPATCH:   w = mk(DP_NOP, COND_OP_ALLOC, S_ALLOC, COND_OP_FREE, S_FREE, S_OP_RZ);
            S_OP_RZ:      w = mk(DP_NOP, COND_OP_RESIZE, S_RZ, COND_NONE, S_IDLE, S_EMIT);
            S_ALLOC:      w = mk(DP_NOP, COND_SIZE_ZERO, S_EMIT, COND_SIZE_BIG, S_TOO_BIG,
                                 S_PLACE_INIT);
            S_TOO_BIG:    w = mk(DP_ST_TOO_BIG, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_EMIT);
            S_PLACE_INIT: w = mk(DP_SCAN_INIT, COND_NONE, S_IDLE, COND_NONE, S_IDLE,
                                 S_PLACE_SCAN);
            S_PLACE_SCAN: w = mk(DP_SCAN_PLACE, COND_SCAN_END, S_APPEND_CHK, COND_HIT_PLACE,
                                 S_PLACE_HIT, S_PLACE_SCAN);
            S_PLACE_HIT:  w = mk(DP_PLACE_HIT, COND_MOVING, S_MOVE, COND_NONE, S_IDLE, S_EMIT);
            S_APPEND_CHK: w = mk(DP_NOP, COND_FULL, S_FULL, COND_NONE, S_IDLE, S_APPEND);
            S_FULL:       w = mk(DP_ST_FULL, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_EMIT);
            S_APPEND:     w = mk(DP_APPEND, COND_MOVING, S_MOVE, COND_NONE, S_IDLE, S_EMIT);
            S_MOVE:       w = mk(DP_MOVE, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_EMIT);
            S_FREE:       w = mk(DP_NOP, COND_ADDR_ZERO, S_EMIT, COND_NONE, S_IDLE,
                                 S_FIND_INIT);
            S_RZ:         w = mk(DP_NOP, COND_ADDR_ZERO, S_ALLOC, COND_NONE, S_IDLE,
                                 S_FIND_INIT);
            S_FIND_INIT:  w = mk(DP_SCAN_INIT, COND_NONE, S_IDLE, COND_NONE, S_IDLE,
                                 S_FIND_SCAN);
            S_FIND_SCAN:  w = mk(DP_SCAN_FIND, COND_SCAN_END, S_NOT_FOUND, COND_HIT_FIND,
                                 S_FOUND, S_FIND_SCAN);
            S_NOT_FOUND:  w = mk(DP_ST_NOT_FOUND, COND_NONE, S_IDLE, COND_NONE, S_IDLE,
                                 S_EMIT);
            S_FOUND:      w = mk(DP_LATCH_K, COND_OP_FREE, S_FREE_K, COND_NONE, S_IDLE,
                                 S_RZ_CHK);
            S_FREE_K:     w = mk(DP_FREE_K, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_EMIT);
            S_RZ_CHK:     w = mk(DP_NOP, COND_FITS_IN, S_RZ_IN, COND_SIZE_BIG, S_TOO_BIG,
                                 S_PLACE_INIT);
            S_RZ_IN:      w = mk(DP_RESIZE_IN, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_EMIT);
            S_EMIT:       w = mk(DP_NOP, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_IDLE);
            default:      w = mk(DP_NOP, COND_NONE, S_IDLE, COND_NONE, S_IDLE, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

### hdl/ffsca_seq.sv
// ffsca_seq: step counter of the allocator, reads the control store and resolves jumps
// depends on ffsca_pkg
module ffsca_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffsca_pkg::t_flags i_flags,
    output ffsca_pkg::t_cw    o_cw,
    output logic              o_busy,
    output logic              o_done,
    output logic              o_accept
);

    ffsca_pkg::t_step r_step;
    ffsca_pkg::t_step n_step;

    function automatic logic cond_true(input ffsca_pkg::t_cond c, input ffsca_pkg::t_flags f,
                                       input logic start);
        logic t;
        case (c)
            ffsca_pkg::COND_NONE:      t = 1'b0;
            ffsca_pkg::COND_START:     t = start;
            ffsca_pkg::COND_OP_ALLOC:  t = f.op_alloc;
            ffsca_pkg::COND_OP_FREE:   t = f.op_free;
            ffsca_pkg::COND_OP_RESIZE: t = f.op_resize;
            ffsca_pkg::COND_SIZE_ZERO: t = f.size_zero;
            ffsca_pkg::COND_SIZE_BIG:  t = f.size_big;
            ffsca_pkg::COND_ADDR_ZERO: t = f.addr_zero;
            ffsca_pkg::COND_SCAN_END:  t = f.scan_end;
            ffsca_pkg::COND_HIT_FIND:  t = f.hit_find;
            ffsca_pkg::COND_HIT_PLACE: t = f.hit_place;
            ffsca_pkg::COND_FULL:      t = f.full;
            ffsca_pkg::COND_FITS_IN:   t = f.fits_in;
            ffsca_pkg::COND_MOVING:    t = f.moving;
            default:                   t = 1'b0;
        endcase
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ffsca_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // next step
    always_comb begin
        if (cond_true(o_cw.cond_a, i_flags, i_start)) begin
            n_step = o_cw.tgt_a;
        end else if (cond_true(o_cw.cond_b, i_flags, i_start)) begin
            n_step = o_cw.tgt_b;
        end else begin
            n_step = o_cw.nxt;
        end
    end

    // outputs
    always_comb begin
        o_cw     = ffsca_pkg::ucode(r_step);
        o_busy   = (r_step != ffsca_pkg::S_IDLE);
        o_done   = (r_step == ffsca_pkg::S_EMIT);
        o_accept = i_start && (r_step == ffsca_pkg::S_IDLE);
    end

endmodule

### hdl/ffsca_dp.sv
// ffsca_dp: datapath of the allocator: block table memories, walk registers, heap state
// depends on ffsca_pkg; driven by the control words of ffsca_seq
module ffsca_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffsca_pkg::t_dp_act                 i_act,
    input  logic                               i_accept,
    input  logic                               i_cfg_wr_en,
    input  logic [ffsca_pkg::ADDR_W-1:0]       i_cfg_wr_data,
    input  logic [ffsca_pkg::OP_W-1:0]         i_operation,
    input  logic [ffsca_pkg::SIZE_W-1:0]       i_request_size,
    input  logic [ffsca_pkg::ADDR_W-1:0]       i_block_address,
    output ffsca_pkg::t_flags                  o_flags,
    output logic [ffsca_pkg::ADDR_W-1:0]       o_result_address,
    output logic [ffsca_pkg::USED_W-1:0]       o_copy_bytes,
    output logic [ffsca_pkg::STATUS_W-1:0]     o_status
);

    logic [ffsca_pkg::USED_W-1:0]  r_mem_used [ffsca_pkg::MAX_BLOCKS];
    logic [ffsca_pkg::CLASS_W-1:0] r_mem_cls  [ffsca_pkg::MAX_BLOCKS];
    logic [ffsca_pkg::USED_W-1:0]  r_rd_used;
    logic [ffsca_pkg::CLASS_W-1:0] r_rd_cls;

    logic [ffsca_pkg::ADDR_W-1:0]   r_heap_base, n_heap_base;
    logic [ffsca_pkg::ADDR_W-1:0]   r_heap_end, n_heap_end;
    logic [ffsca_pkg::CNT_W-1:0]    r_count, n_count;
    logic [ffsca_pkg::OP_W-1:0]     r_op, n_op;
    logic [ffsca_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [ffsca_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [ffsca_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic [ffsca_pkg::ADDR_W-1:0]   r_hdr, n_hdr;
    logic [ffsca_pkg::IDX_W-1:0]    r_k, n_k;
    logic [ffsca_pkg::CLASS_W-1:0]  r_k_cls, n_k_cls;
    logic [ffsca_pkg::USED_W-1:0]   r_k_used, n_k_used;
    logic [ffsca_pkg::ADDR_W-1:0]   r_result, n_result;
    logic [ffsca_pkg::USED_W-1:0]   r_copy, n_copy;
    logic [ffsca_pkg::STATUS_W-1:0] r_status, n_status;

    logic                          we_used;
    logic                          we_cls;
    logic [ffsca_pkg::IDX_W-1:0]   wr_addr;
    logic [ffsca_pkg::USED_W-1:0]  wr_used;
    logic [ffsca_pkg::CLASS_W-1:0] new_cls;
    logic [ffsca_pkg::IDX_W-1:0]   rd_addr;
    logic [ffsca_pkg::ADDR_W-1:0]  data_addr;
    logic [ffsca_pkg::ADDR_W-1:0]  end_data;
    logic                          scan_hit;

    assign new_cls   = ffsca_pkg::fit_class(r_size);
    assign data_addr = r_hdr + 32'(ffsca_pkg::HEADER_BYTES);
    assign end_data  = r_heap_end + 32'(ffsca_pkg::HEADER_BYTES);
    assign rd_addr   = n_idx[ffsca_pkg::IDX_W-1:0];

    always_comb begin
        o_flags.op_alloc  = (r_op == ffsca_pkg::OP_ALLOC);
        o_flags.op_free   = (r_op == ffsca_pkg::OP_FREE);
        o_flags.op_resize = (r_op == ffsca_pkg::OP_RESIZE);
        o_flags.size_zero = (r_size == '0);
        o_flags.size_big  = (r_size > 16'(ffsca_pkg::LARGEST_CLASS));
        o_flags.addr_zero = (r_addr == '0);
        o_flags.scan_end  = (r_idx == r_count);
        o_flags.hit_find  = (data_addr == r_addr);
        o_flags.hit_place = (r_rd_used == '0) &&
                            ({1'b0, ffsca_pkg::class_bytes(r_rd_cls)} >= r_size);
        o_flags.full      = (r_count == ffsca_pkg::CNT_W'(ffsca_pkg::MAX_BLOCKS));
        o_flags.fits_in   = (r_size < {1'b0, ffsca_pkg::class_bytes(r_k_cls)});
        o_flags.moving    = (r_op == ffsca_pkg::OP_RESIZE) && (r_addr != '0);
    end

    always_comb begin
        if (i_act == ffsca_pkg::DP_SCAN_FIND) begin
            scan_hit = o_flags.hit_find;
        end else begin
            scan_hit = o_flags.hit_place;
        end
    end

    always_comb begin
        n_heap_base = r_heap_base;
        n_heap_end  = r_heap_end;
        n_count     = r_count;
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_hdr       = r_hdr;
        n_k         = r_k;
        n_k_cls     = r_k_cls;
        n_k_used    = r_k_used;
        n_result    = r_result;
        n_copy      = r_copy;
        n_status    = r_status;
        we_used     = 1'b0;
        we_cls      = 1'b0;
        wr_addr     = r_k;
        wr_used     = '0;

        if (i_accept) begin
            n_op     = i_operation;
            n_size   = i_request_size;
            n_addr   = i_block_address;
            n_result = '0;
            n_copy   = '0;
            n_status = ffsca_pkg::ST_EMPTY;
        end

        case (i_act)
            ffsca_pkg::DP_NOP: begin
            end
            ffsca_pkg::DP_SCAN_INIT: begin
                n_idx = '0;
                n_hdr = r_heap_base;
            end
            ffsca_pkg::DP_SCAN_FIND, ffsca_pkg::DP_SCAN_PLACE: begin
                if (!o_flags.scan_end && !scan_hit) begin
                    n_idx = r_idx + 1'b1;
                    n_hdr = r_hdr + 32'(ffsca_pkg::HEADER_BYTES) +
                            32'(ffsca_pkg::class_bytes(r_rd_cls));
                end
            end
            ffsca_pkg::DP_LATCH_K: begin
                n_k      = r_idx[ffsca_pkg::IDX_W-1:0];
                n_k_cls  = r_rd_cls;
                n_k_used = r_rd_used;
            end
            ffsca_pkg::DP_PLACE_HIT: begin
                we_used  = 1'b1;
                wr_addr  = r_idx[ffsca_pkg::IDX_W-1:0];
                wr_used  = r_size[ffsca_pkg::USED_W-1:0];
                n_result = data_addr;
                n_status = ffsca_pkg::ST_OK;
            end
            ffsca_pkg::DP_APPEND: begin
                we_used    = 1'b1;
                we_cls     = 1'b1;
                wr_addr    = r_count[ffsca_pkg::IDX_W-1:0];
                wr_used    = r_size[ffsca_pkg::USED_W-1:0];
                n_result   = end_data;
                n_heap_end = end_data + 32'(ffsca_pkg::class_bytes(new_cls));
                n_count    = r_count + 1'b1;
                n_status   = ffsca_pkg::ST_OK;
            end
            ffsca_pkg::DP_MOVE: begin
                we_used = 1'b1;
                if ({1'b0, r_k_used} < r_size) begin
                    n_copy = r_k_used;
                end else begin
                    n_copy = r_size[ffsca_pkg::USED_W-1:0];
                end
            end
            ffsca_pkg::DP_FREE_K: begin
                we_used  = 1'b1;
                n_status = ffsca_pkg::ST_OK;
            end
            ffsca_pkg::DP_RESIZE_IN: begin
                we_used = 1'b1;
                wr_used = r_size[ffsca_pkg::USED_W-1:0];
                if (r_size == '0) begin
                    n_status = ffsca_pkg::ST_EMPTY;
                end else begin
                    n_result = r_addr;
                    n_status = ffsca_pkg::ST_OK;
                end
            end
            ffsca_pkg::DP_ST_TOO_BIG: begin
                n_status = ffsca_pkg::ST_TOO_BIG;
            end
            ffsca_pkg::DP_ST_FULL: begin
                n_status = ffsca_pkg::ST_FULL;
            end
            ffsca_pkg::DP_ST_NOT_FOUND: begin
                n_status = ffsca_pkg::ST_NOT_FOUND;
            end
            default: begin
            end
        endcase

        if (i_cfg_wr_en) begin
            n_heap_base = i_cfg_wr_data;
            n_heap_end  = i_cfg_wr_data;
            n_count     = '0;
        end
    end

    // block table
    always_ff @(posedge i_clk) begin
        if (we_used) begin
            r_mem_used[wr_addr] <= wr_used;
        end
        if (we_cls) begin
            r_mem_cls[wr_addr] <= new_cls;
        end
        r_rd_used <= r_mem_used[rd_addr];
        r_rd_cls  <= r_mem_cls[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_end  <= '0;
            r_count     <= '0;
        end else begin
            r_heap_base <= n_heap_base;
            r_heap_end  <= n_heap_end;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_hdr    <= n_hdr;
        r_k      <= n_k;
        r_k_cls  <= n_k_cls;
        r_k_used <= n_k_used;
        r_result <= n_result;
        r_copy   <= n_copy;
        r_status <= n_status;
    end

    assign o_result_address = r_result;
    assign o_copy_bytes     = r_copy;
    assign o_status         = r_status;

endmodule

### hdl/first_fit_size_class_allocator_core.sv
// first_fit_size_class_allocator_core: top level of the first-fit size-class allocator
// depends on ffsca_pkg, ffsca_seq and ffsca_dp
//
// usage
// - a request (operation, request_size, block_address) is taken at a clock edge with
//   start high and busy low; busy stays high until the result has been shown
// - exactly one result per request: o_result_address, o_copy_bytes and o_status are
//   valid for the single cycle in which o_done is high, and taken at the edge ending it
// - the receiver cannot stall; the block returns to idle in the cycle after o_done
// - heap_base is written through i_cfg_wr_en / i_cfg_wr_data while idle; the user must
//   keep to this, the block does not enforce it; a write also empties the heap
// - free and allocate walk the block table (at most 64 entries) once; a resize that
//   moves its block walks the table twice
// - the rate is set by the walk over the block table memory, one entry per cycle,
//   under control of the microcode sequencer
// - after reset the heap is empty at base address 0; no clearing pass is needed
module first_fit_size_class_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_wr_en,
    input  logic [ffsca_pkg::ADDR_W-1:0]   i_cfg_wr_data,
    input  logic [ffsca_pkg::OP_W-1:0]     i_operation,
    input  logic [ffsca_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffsca_pkg::ADDR_W-1:0]   i_block_address,
    output logic                           o_done,
    output logic [ffsca_pkg::ADDR_W-1:0]   o_result_address,
    output logic [ffsca_pkg::USED_W-1:0]   o_copy_bytes,
    output logic [ffsca_pkg::STATUS_W-1:0] o_status
);

    ffsca_pkg::t_cw    cw;
    ffsca_pkg::t_flags flags;
    logic              accept;

    ffsca_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_flags  (flags),
        .o_cw     (cw),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_accept (accept)
    );

    ffsca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_act            (cw.act),
        .i_accept         (accept),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_operation      (i_operation),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .o_flags          (flags),
        .o_result_address (o_result_address),
        .o_copy_bytes     (o_copy_bytes),
        .o_status         (o_status)
    );

endmodule

### hdl/ffsca_checker.sv
// ffsca_checker: port-level assertions for the allocator core, bound to the top level
// depends on ffsca_pkg and first_fit_size_class_allocator_core
module ffsca_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic [ffsca_pkg::ADDR_W-1:0]   o_result_address,
    input logic [ffsca_pkg::USED_W-1:0]   o_copy_bytes,
    input logic [ffsca_pkg::STATUS_W-1:0] o_status
);

    // a result only appears while a transaction is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // one result per transaction, then idle
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ffsca_pkg::ST_OK)) |-> (o_result_address == '0))
        else $error("address returned with failing status");

    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_copy_bytes != '0)) |-> (o_status == ffsca_pkg::ST_OK))
        else $error("copy length reported without success");

endmodule

bind first_fit_size_class_allocator_core ffsca_checker u_ffsca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_result_address (o_result_address),
    .o_copy_bytes     (o_copy_bytes),
    .o_status         (o_status)
);
